// ----- hw/rtl/hdsc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hdsc_pkg
// Shared types and constants of the half-duplex smart card character
// transceiver: transaction payloads, register set and request codes.
// ----------------------------------------------------------------------------
package hdsc_pkg;

    // request codes carried in the func field
    localparam logic [1:0] FUNC_SEND = 2'd1;
    localparam logic [1:0] FUNC_RECV = 2'd2;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_BIT_TIME      = 2'd0;
    localparam logic [1:0] CFG_SAMPLE_OFFSET = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT       = 2'd2;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 24;

    // register reset values
    localparam logic [15:0] BIT_TIME_RST      = 16'd104;
    localparam logic [15:0] SAMPLE_OFFSET_RST = 16'd30;
    localparam logic [23:0] TIMEOUT_RST       = 24'h600000;

    // frame slots: start, eight data, parity, two guard
    localparam logic [3:0] DATA_BITS = 4'd8;
    localparam logic [3:0] LAST_SLOT = 4'd11;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] send_byte;
        logic [6:0] receive_count;
        logic       line_in;
    } in_item_t;

    typedef struct packed {
        logic       line_out;
        logic       line_drive;
        logic       busy_res;
        logic       got_valid;
        logic [7:0] got_byte;
        logic       got_last;
        logic       timed_out;
        logic       send_done;
    } out_item_t;

    typedef struct packed {
        logic [15:0] bit_time_ticks;
        logic [15:0] sample_offset_ticks;
        logic [23:0] timeout_ticks;
    } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/hdsc_step_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hdsc_step_engine
// Transceiver state and the per-tick update: transmit framing, receive
// sampling with start detection, and the accumulated start-bit timeout.
// ----------------------------------------------------------------------------
module hdsc_step_engine
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step_en,
    input  wire hdsc_pkg::in_item_t item,
    input  wire hdsc_pkg::cfg_t     cfg,
    output hdsc_pkg::out_item_t     result
);

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_TX        = 3'd1,
        MODE_RX_WAIT   = 3'd2,
        MODE_RX_OFFSET = 3'd3,
        MODE_RX_BITS   = 3'd4,
        MODE_RX_SKIP   = 3'd5
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic [15:0] tick_timer_reg, tick_timer_next;
    logic [23:0] wait_counter_reg, wait_counter_next;
    logic [3:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_byte_reg, shift_byte_next;
    logic        parity_bit_reg, parity_bit_next;
    logic [6:0]  bytes_left_reg, bytes_left_next;

    logic        armed;
    logic [16:0] tick_inc;
    logic [15:0] bit_len;
    logic [24:0] wait_inc;
    logic [23:0] wait_lim;
    logic        bit_end;

    assign tick_inc = {1'b0, tick_timer_reg} + 17'd1;
    assign bit_len  = (cfg.bit_time_ticks == 16'd0) ? 16'd1 : cfg.bit_time_ticks;
    assign wait_inc = {1'b0, wait_counter_reg} + 25'd1;
    assign wait_lim = (cfg.timeout_ticks == 24'd0) ? 24'd1 : cfg.timeout_ticks;
    assign bit_end  = (tick_inc >= {1'b0, bit_len});

    always_comb
    begin
        mode_next         = mode_reg;
        tick_timer_next   = tick_timer_reg;
        wait_counter_next = wait_counter_reg;
        bit_index_next    = bit_index_reg;
        shift_byte_next   = shift_byte_reg;
        parity_bit_next   = parity_bit_reg;
        bytes_left_next   = bytes_left_reg;
        armed             = 1'b0;
        result            = '0;
        result.line_out   = 1'b1;

        if (mode_reg == MODE_IDLE)
        begin
            if (item.func == hdsc_pkg::FUNC_SEND)
            begin
                mode_next       = MODE_TX;
                shift_byte_next = item.send_byte;
                parity_bit_next = ^item.send_byte;
                bit_index_next  = '0;
                tick_timer_next = '0;
            end
            else if (item.func == hdsc_pkg::FUNC_RECV && item.receive_count != 7'd0)
            begin
                mode_next         = MODE_RX_WAIT;
                bytes_left_next   = item.receive_count;
                wait_counter_next = '0;
                tick_timer_next   = '0;
                bit_index_next    = '0;
                shift_byte_next   = '0;
                parity_bit_next   = 1'b0;
                armed             = 1'b1;
            end
        end

        // a fresh send request starts on this same tick; a receive only arms
        if (!armed)
        begin
            unique case (mode_next)
                MODE_TX:
                begin
                    result.line_drive = 1'b1;
                    if (bit_index_next == 4'd0)
                        result.line_out = 1'b0;
                    else if (bit_index_next <= hdsc_pkg::DATA_BITS)
                        result.line_out = shift_byte_next[3'(bit_index_next - 4'd1)];
                    else if (bit_index_next == hdsc_pkg::DATA_BITS + 4'd1)
                        result.line_out = parity_bit_next;
                    else
                        result.line_out = 1'b1;

                    if (bit_end)
                    begin
                        tick_timer_next = '0;
                        if (bit_index_next >= hdsc_pkg::LAST_SLOT)
                        begin
                            result.send_done = 1'b1;
                            bit_index_next   = '0;
                            mode_next        = MODE_IDLE;
                        end
                        else
                            bit_index_next = bit_index_next + 4'd1;
                    end
                    else
                        tick_timer_next = tick_inc[15:0];
                end
                MODE_RX_WAIT:
                begin
                    if (item.line_in)
                    begin
                        wait_counter_next = wait_inc[23:0];
                        if (wait_inc >= {1'b0, wait_lim})
                        begin
                            result.timed_out = 1'b1;
                            mode_next        = MODE_IDLE;
                        end
                    end
                    else
                    begin
                        tick_timer_next = '0;
                        shift_byte_next = '0;
                        bit_index_next  = '0;
                        mode_next = (cfg.sample_offset_ticks != 16'd0) ? MODE_RX_OFFSET
                                                                        : MODE_RX_BITS;
                    end
                end
                MODE_RX_OFFSET:
                begin
                    if (tick_inc >= {1'b0, cfg.sample_offset_ticks})
                    begin
                        tick_timer_next = '0;
                        mode_next       = MODE_RX_BITS;
                    end
                    else
                        tick_timer_next = tick_inc[15:0];
                end
                MODE_RX_BITS:
                begin
                    if (bit_end)
                    begin
                        tick_timer_next = '0;
                        if (item.line_in)
                            shift_byte_next[bit_index_next[2:0]] = 1'b1;
                        bit_index_next = bit_index_next + 4'd1;
                        if (bit_index_next >= hdsc_pkg::DATA_BITS)
                        begin
                            bit_index_next   = hdsc_pkg::DATA_BITS;
                            result.got_valid = 1'b1;
                            result.got_byte  = shift_byte_next;
                            if (bytes_left_next != 7'd0)
                                bytes_left_next = bytes_left_next - 7'd1;
                            result.got_last  = (bytes_left_next == 7'd0);
                            mode_next        = MODE_RX_SKIP;
                        end
                    end
                    else
                        tick_timer_next = tick_inc[15:0];
                end
                MODE_RX_SKIP:
                begin
                    if (bit_end)
                    begin
                        tick_timer_next = '0;
                        bit_index_next  = bit_index_next + 4'd1;
                        if (bit_index_next >= hdsc_pkg::LAST_SLOT)
                        begin
                            bit_index_next = '0;
                            mode_next = (bytes_left_next != 7'd0) ? MODE_RX_WAIT : MODE_IDLE;
                        end
                    end
                    else
                        tick_timer_next = tick_inc[15:0];
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                end
            endcase
        end

        result.busy_res = (mode_next != MODE_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            tick_timer_reg   <= '0;
            wait_counter_reg <= '0;
            bit_index_reg    <= '0;
            shift_byte_reg   <= '0;
            parity_bit_reg   <= 1'b0;
            bytes_left_reg   <= '0;
        end
        else if (step_en)
        begin
            mode_reg         <= mode_next;
            tick_timer_reg   <= tick_timer_next;
            wait_counter_reg <= wait_counter_next;
            bit_index_reg    <= bit_index_next;
            shift_byte_reg   <= shift_byte_next;
            parity_bit_reg   <= parity_bit_next;
            bytes_left_reg   <= bytes_left_next;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/half_duplex_smartcard_char_transceiver_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// half_duplex_smartcard_char_transceiver_core
// Tick-driven single-wire character transceiver with ISO 7816 style framing.
//
// Each input transaction on in_item is one time tick: a plain tick, a send
// request or a receive request, plus the sampled line level. Every input
// transaction yields exactly one output transaction on out_item carrying the
// driven line level, drive enable, busy flag and any received byte, timeout
// or send-done event for that tick.
// Path: a taken input enters the input register, then one update pass
// writes its result into the output register, from which it can be taken.
// Throughput: one tick per clock cycle while out_stall does not hold the
// output register, set by the single state-update pass.
// Reset: registers return to 104 / 30 / 0x600000 ticks, the transceiver goes
// idle and both pipeline registers empty.
// When out_stall is high the result holds, one more tick waits in the input
// register, and in_stall then rises until the output is taken.
// cfg_we writes register cfg_index (0 bit time, 1 sample offset, 2 timeout)
// from cfg_wdata; write only while no transaction is in flight.
// ----------------------------------------------------------------------------
module half_duplex_smartcard_char_transceiver_core
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire hdsc_pkg::in_item_t                 in_item,

    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output hdsc_pkg::out_item_t                     out_item,

    input  wire logic                               cfg_we,
    input  wire logic [hdsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [hdsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    hdsc_pkg::cfg_t      cfg_reg;
    logic                in_valid_reg;
    hdsc_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    hdsc_pkg::out_item_t out_item_reg;
    hdsc_pkg::out_item_t step_result;
    logic                advance;
    logic                step_en;
    logic                in_take;

    assign advance  = !out_valid_reg || !out_stall;
    assign step_en  = in_valid_reg && advance;
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_time_ticks      <= hdsc_pkg::BIT_TIME_RST;
            cfg_reg.sample_offset_ticks <= hdsc_pkg::SAMPLE_OFFSET_RST;
            cfg_reg.timeout_ticks       <= hdsc_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hdsc_pkg::CFG_BIT_TIME:      cfg_reg.bit_time_ticks      <= cfg_wdata[15:0];
                hdsc_pkg::CFG_SAMPLE_OFFSET: cfg_reg.sample_offset_ticks <= cfg_wdata[15:0];
                hdsc_pkg::CFG_TIMEOUT:       cfg_reg.timeout_ticks       <= cfg_wdata;
                default:                     ;
            endcase
        end
    end

    // input register: refill while draining, hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_take)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= in_item;
    end

    hdsc_step_engine u_engine
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_item_reg <= step_result;
    end

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the half-duplex smart card character transceiver core.
//
// Every input transaction is one time tick. A cycle-level predictor kept in
// this module follows the transceiver state for each accepted tick and
// queues the expected output transaction, which is compared field by field
// with what the core returns. Directed tests cover reset values, the framing
// of sent bytes, receive counts including the ignored and the widest ones,
// timeouts that add up over a request and the slowest register settings.
// Random traffic then mixes sends, receives fed by a simulated card and line
// noise under four idling profiles of the two handshakes.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_RSVD = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_WAIT_START,
        S_OFFSET,
        S_SAMPLE,
        S_SKIP
    } xcvr_state_e;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 in_valid = 1'b0;
    logic                                 in_stall;
    hdsc_pkg::in_item_t                   in_item = '0;
    logic                                 out_valid;
    logic                                 out_stall = 1'b0;
    hdsc_pkg::out_item_t                  out_item;
    logic                                 cfg_we = 1'b0;
    logic [hdsc_pkg::CFG_INDEX_W-1:0]     cfg_index = hdsc_pkg::CFG_BIT_TIME;
    logic [23:0]                          cfg_wdata = '0;

    // predictor copy of registers and transceiver state
    logic [15:0] bit_time = hdsc_pkg::BIT_TIME_RST;
    logic [15:0] sample_offset = hdsc_pkg::SAMPLE_OFFSET_RST;
    logic [23:0] timeout_limit = hdsc_pkg::TIMEOUT_RST;
    xcvr_state_e xcvr_state = S_IDLE;
    logic [15:0] slot_timer = '0;
    logic [23:0] idle_wait = '0;
    logic [3:0]  slot_idx = '0;
    logic [7:0]  shreg = '0;
    logic        par_bit = 1'b0;
    logic [6:0]  bytes_to_go = '0;

    hdsc_pkg::out_item_t expected_ticks[$];
    int unsigned ticks_sent = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches = 0;
    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;

    half_duplex_smartcard_char_transceiver_core DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // One tick of the transceiver: update state, return the expected output.
    function automatic hdsc_pkg::out_item_t step_transceiver(hdsc_pkg::in_item_t it);
        hdsc_pkg::out_item_t res;
        logic        armed;
        int unsigned nxt;
        int unsigned slot_len;
        int unsigned waited;
        int unsigned limit;
        res = '0;
        res.line_out = 1'b1;
        armed = 1'b0;
        slot_len = (bit_time == '0) ? 1 : bit_time;
        limit = (timeout_limit == '0) ? 1 : timeout_limit;
        if (xcvr_state == S_IDLE)
        begin
            if (it.func == hdsc_pkg::FUNC_SEND)
            begin
                xcvr_state = S_SEND;
                shreg = it.send_byte;
                par_bit = ^it.send_byte;
                slot_idx = '0;
                slot_timer = '0;
            end
            else if (it.func == hdsc_pkg::FUNC_RECV && it.receive_count != '0)
            begin
                xcvr_state = S_WAIT_START;
                bytes_to_go = it.receive_count;
                idle_wait = '0;
                slot_timer = '0;
                slot_idx = '0;
                shreg = '0;
                par_bit = 1'b0;
                armed = 1'b1;
            end
        end
        if (!armed)
        begin
            nxt = slot_timer + 1;
            case (xcvr_state)
                S_SEND:
                begin
                    res.line_drive = 1'b1;
                    if (slot_idx == '0)
                        res.line_out = 1'b0;
                    else if (slot_idx <= hdsc_pkg::DATA_BITS)
                        res.line_out = shreg[slot_idx - 1];
                    else if (slot_idx == hdsc_pkg::DATA_BITS + 1)
                        res.line_out = par_bit;
                    if (nxt >= slot_len)
                    begin
                        slot_timer = '0;
                        if (slot_idx >= hdsc_pkg::LAST_SLOT)
                        begin
                            res.send_done = 1'b1;
                            slot_idx = '0;
                            xcvr_state = S_IDLE;
                        end
                        else
                            slot_idx++;
                    end
                    else
                        slot_timer = 16'(nxt);
                end
                S_WAIT_START:
                begin
                    if (it.line_in)
                    begin
                        // idle ticks add up over the whole request
                        waited = idle_wait + 1;
                        idle_wait = 24'(waited);
                        if (waited >= limit)
                        begin
                            res.timed_out = 1'b1;
                            xcvr_state = S_IDLE;
                        end
                    end
                    else
                    begin
                        slot_timer = '0;
                        shreg = '0;
                        slot_idx = '0;
                        xcvr_state = (sample_offset != '0) ? S_OFFSET : S_SAMPLE;
                    end
                end
                S_OFFSET:
                begin
                    if (nxt >= sample_offset)
                    begin
                        slot_timer = '0;
                        xcvr_state = S_SAMPLE;
                    end
                    else
                        slot_timer = 16'(nxt);
                end
                S_SAMPLE:
                begin
                    if (nxt >= slot_len)
                    begin
                        slot_timer = '0;
                        if (it.line_in)
                            shreg[slot_idx[2:0]] = 1'b1;
                        slot_idx++;
                        if (slot_idx >= hdsc_pkg::DATA_BITS)
                        begin
                            slot_idx = hdsc_pkg::DATA_BITS;
                            res.got_valid = 1'b1;
                            res.got_byte = shreg;
                            if (bytes_to_go != '0)
                                bytes_to_go--;
                            res.got_last = (bytes_to_go == '0);
                            xcvr_state = S_SKIP;
                        end
                    end
                    else
                        slot_timer = 16'(nxt);
                end
                S_SKIP:
                begin
                    // parity and guard pass unchecked
                    if (nxt >= slot_len)
                    begin
                        slot_timer = '0;
                        slot_idx++;
                        if (slot_idx >= hdsc_pkg::LAST_SLOT)
                        begin
                            slot_idx = '0;
                            xcvr_state = (bytes_to_go != '0) ? S_WAIT_START : S_IDLE;
                        end
                    end
                    else
                        slot_timer = 16'(nxt);
                end
                default:
                begin
                end
            endcase
        end
        res.busy_res = (xcvr_state != S_IDLE);
        return res;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR: result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    always @(posedge clk)
    begin : check_results
        hdsc_pkg::out_item_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            results_seen++;
            if (expected_ticks.size() == 0)
                report_mismatch("output transaction with no tick waiting for it");
            else
            begin
                want = expected_ticks.pop_front();
                check_field("line_out", out_item.line_out, want.line_out);
                check_field("line_drive", out_item.line_drive, want.line_drive);
                check_field("busy_res", out_item.busy_res, want.busy_res);
                check_field("got_valid", out_item.got_valid, want.got_valid);
                check_field("got_byte", out_item.got_byte, want.got_byte);
                check_field("got_last", out_item.got_last, want.got_last);
                check_field("timed_out", out_item.timed_out, want.timed_out);
                check_field("send_done", out_item.send_done, want.send_done);
            end
        end
    end

    // Send one tick transaction; valid stays high until a gap lowers it.
    task automatic drive_tick(logic [1:0] f, logic [7:0] sb, logic [6:0] rc, logic li);
        hdsc_pkg::in_item_t it;
        it.func = f;
        it.send_byte = sb;
        it.receive_count = rc;
        it.line_in = li;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_ticks.push_back(step_transceiver(it));
        ticks_sent++;
    endtask

    // Tick with a given line level; requests only where they are ignored.
    task automatic line_tick(logic li);
        logic [1:0] f;
        if (xcvr_state == S_IDLE)
            f = $urandom_range(1) ? FUNC_RSVD : FUNC_TICK;
        else
            f = 2'($urandom_range(3));
        drive_tick(f, 8'($urandom), 7'($urandom), li);
    endtask

    task automatic run_until_idle(logic quiet_line);
        while (xcvr_state != S_IDLE)
            line_tick(quiet_line ? 1'b1 : 1'($urandom));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_ticks.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Finish any transfer, then let the pipeline empty.
    task automatic go_quiet();
        while (xcvr_state != S_IDLE)
            line_tick(xcvr_state != S_WAIT_START);
        drain_results();
    endtask

    task automatic write_reg(logic [hdsc_pkg::CFG_INDEX_W-1:0] idx, logic [23:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            hdsc_pkg::CFG_BIT_TIME:      bit_time = val[15:0];
            hdsc_pkg::CFG_SAMPLE_OFFSET: sample_offset = val[15:0];
            hdsc_pkg::CFG_TIMEOUT:       timeout_limit = val;
            default:
            begin
            end
        endcase
    endtask

    // Change one register in the middle of a transfer, pipeline empty.
    task automatic retime(logic [hdsc_pkg::CFG_INDEX_W-1:0] idx, logic [23:0] val);
        drain_results();
        write_reg(idx, val);
        cfg_we <= 1'b0;
    endtask

    task automatic set_timing(logic [15:0] bt, logic [15:0] off, logic [23:0] tmo);
        go_quiet();
        write_reg(hdsc_pkg::CFG_BIT_TIME, {8'd0, bt});
        write_reg(hdsc_pkg::CFG_SAMPLE_OFFSET, {8'd0, off});
        write_reg(hdsc_pkg::CFG_TIMEOUT, tmo);
        cfg_we <= 1'b0;
    endtask

    task automatic transmit_byte(logic [7:0] b);
        drive_tick(hdsc_pkg::FUNC_SEND, b, 7'($urandom), 1'($urandom));
        run_until_idle(1'b0);
    endtask

    // Card side: one character frame at the current bit time.
    task automatic play_frame(logic [7:0] card, logic bad_parity);
        int unsigned len;
        int unsigned slot;
        logic        level;
        len = (bit_time == '0) ? 1 : bit_time;
        for (slot = 0; slot <= hdsc_pkg::LAST_SLOT; slot++)
        begin
            if (slot == 0)
                level = 1'b0;
            else if (slot <= hdsc_pkg::DATA_BITS)
                level = card[slot - 1];
            else if (slot == hdsc_pkg::DATA_BITS + 1)
                level = ^card ^ bad_parity;
            else
                level = 1'b1;
            repeat (len) line_tick(level);
        end
    endtask

    task automatic receive_frames(logic [6:0] count, int unsigned gap_max,
                                  int unsigned glitch_pct);
        drive_tick(hdsc_pkg::FUNC_RECV, 8'($urandom), count, 1'($urandom));
        while (xcvr_state != S_IDLE)
        begin
            repeat ($urandom_range(gap_max))
                line_tick($urandom_range(99) >= glitch_pct);
            play_frame(8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_reset_values();
        // reset offset and bit time up to the first data sample
        drive_tick(hdsc_pkg::FUNC_RECV, 8'($urandom), 7'd1, 1'($urandom));
        line_tick(1'b0);
        while (xcvr_state != S_SAMPLE || slot_idx == '0)
            line_tick(1'($urandom));
        // a new bit time applies from the next tick on
        retime(hdsc_pkg::CFG_BIT_TIME, 24'd1);
        run_until_idle(1'b0);
    endtask

    task automatic test_send_frames();
        set_timing(16'd1, 16'd0, 24'd100);
        transmit_byte(8'h00);
        transmit_byte(8'hFF);
        drive_tick(FUNC_RSVD, 8'hFF, 7'h7F, 1'b0);
        drive_tick(hdsc_pkg::FUNC_SEND, 8'h55, 7'd0, 1'b0);
        // requests while the frame goes out are dropped
        drive_tick(hdsc_pkg::FUNC_RECV, 8'hAA, 7'd5, 1'b0);
        drive_tick(hdsc_pkg::FUNC_SEND, 8'h0F, 7'd1, 1'b1);
        run_until_idle(1'b0);
        // zero bit time runs as one tick per bit
        set_timing(16'd0, 16'd0, 24'd100);
        transmit_byte(8'h96);
    endtask

    task automatic test_receive_counts();
        set_timing(16'd1, 16'd1, 24'd1000);
        drive_tick(hdsc_pkg::FUNC_RECV, 8'h00, 7'd0, 1'b0);
        line_tick(1'b0);
        receive_frames(7'd1, 2, 0);
        // the widest count stays open across bytes until the wait runs out
        set_timing(16'd1, 16'd0, 24'd4);
        drive_tick(hdsc_pkg::FUNC_RECV, 8'h00, 7'h7F, 1'b1);
        play_frame(8'h5A, 1'b0);
        play_frame(8'hA5, 1'b1);
        run_until_idle(1'b1);
    endtask

    task automatic test_timeouts();
        set_timing(16'd1, 16'd0, 24'd1);
        drive_tick(hdsc_pkg::FUNC_RECV, 8'h00, 7'd1, 1'b1);
        run_until_idle(1'b1);
        set_timing(16'd1, 16'd0, 24'd0);
        drive_tick(hdsc_pkg::FUNC_RECV, 8'h00, 7'd1, 1'b1);
        run_until_idle(1'b1);
        // three idle ticks before each byte; the second wait ends the request
        set_timing(16'd1, 16'd0, 24'd6);
        drive_tick(hdsc_pkg::FUNC_RECV, 8'h00, 7'd2, 1'b1);
        repeat (3) line_tick(1'b1);
        play_frame(8'hC3, 1'b0);
        run_until_idle(1'b1);
    endtask

    task automatic test_slow_registers();
        // widest bit time: start bit still low, then shorten it
        set_timing(16'hFFFF, 16'd0, 24'd4);
        drive_tick(hdsc_pkg::FUNC_SEND, 8'h3C, 7'd0, 1'b0);
        repeat (4) line_tick(1'($urandom));
        retime(hdsc_pkg::CFG_BIT_TIME, 24'd1);
        run_until_idle(1'b0);
        // widest sample offset, then shorten it
        set_timing(16'd1, 16'hFFFF, 24'd50);
        drive_tick(hdsc_pkg::FUNC_RECV, 8'h00, 7'd1, 1'b1);
        line_tick(1'b0);
        repeat (8) line_tick(1'($urandom));
        retime(hdsc_pkg::CFG_SAMPLE_OFFSET, 24'd3);
        run_until_idle(1'b0);
    endtask

    task automatic random_transfer();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 40)
            transmit_byte(8'($urandom));
        else if (pick < 85)
            receive_frames(7'($urandom_range(1, 2)), $urandom_range(3), 10);
        else if (pick < 90)
            drive_tick(hdsc_pkg::FUNC_RECV, 8'($urandom), 7'd0, 1'($urandom));
        else
            repeat ($urandom_range(1, 8)) line_tick(1'($urandom));
    endtask

    task automatic test_random_traffic();
        int unsigned phase;
        int unsigned bt;
        int unsigned first;
        for (phase = 0; phase < 4; phase++)
        begin
            bt = $urandom_range(1, 2);
            set_timing(16'(bt), 16'($urandom_range(bt)),
                       $urandom_range(1) ? 24'($urandom_range(2, 12))
                                         : 24'($urandom_range(100, 4000)));
            idle_pct = (phase == 1) ? 50 : (phase == 3) ? 13 : 0;
            stall_pct = (phase == 2) ? 50 : (phase == 3) ? 13 : 0;
            first = ticks_sent;
            while (ticks_sent - first < 16)
                random_transfer();
            // hold new ticks until every result is back
            drain_results();
            while (ticks_sent - first < 32)
                random_transfer();
        end
        idle_pct = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_send_frames();
        test_receive_counts();
        test_timeouts();
        test_slow_registers();
        test_random_traffic();
        drain_results();
        if (mismatches == 0)
            $display("half_duplex_smartcard_char_transceiver_core test passed");
        else
            $display("half_duplex_smartcard_char_transceiver_core test failed");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("half_duplex_smartcard_char_transceiver_core test failed");
        $finish;
    end

endmodule
`default_nettype wire

// ----- sim.f -----
hw/rtl/hdsc_pkg.sv
hw/rtl/hdsc_step_engine.sv
hw/rtl/half_duplex_smartcard_char_transceiver_core.sv
tb/tb_top.sv
